// ===== design/arfc_pkg.sv =====
package arfc_pkg;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 56;

    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;

    localparam logic [7:0]  START_CHAR_RST = 8'h21;
    localparam logic [7:0]  END_CHAR_RST   = 8'h0D;
    localparam logic [7:0]  SEP_CHAR_RST   = 8'h3B;
    localparam logic [15:0] CRC_PRESET_RST = 16'hFFFF;

    localparam logic [1:0] REG_START_CHAR = 2'd0;
    localparam logic [1:0] REG_END_CHAR   = 2'd1;
    localparam logic [1:0] REG_SEP_CHAR   = 2'd2;
    localparam logic [1:0] REG_CRC_PRESET = 2'd3;

    typedef enum logic [1:0] {
        TOK_NONE     = 2'd0,
        TOK_DOLLAR   = 2'd1,
        TOK_MATCH    = 2'd2,
        TOK_MISMATCH = 2'd3
    } token_t;

    typedef struct packed {
        logic [7:0]  start_char;
        logic [7:0]  end_char;
        logic [7:0]  separator_char;
        logic [15:0] crc_preset;
    } cfg_t;

    typedef struct packed {
        logic [15:0] computed_crc;
        logic        success;
        logic [31:0] field_value;
        logic        frame_valid;
    } result_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== design/ascii_response_frame_checker_top.sv =====
// Channel   Dir  Handshake              Payload
// s_        in   s_tvalid / s_tready    s_tdata[7:0] = rx_byte
// m_        out  m_tvalid / m_tready    m_tdata = frame_valid, field_value, success,
//                                       computed_crc
// cfg_      in   cfg_valid / cfg_ready  cfg_index selects register, cfg_data value
//
// One byte per cycle sustained while the result side is not stalled; the closing
// byte waits in the input register, then the frame logic with its combinational
// CRC byte update writes the result register.
// aresetn is synchronous: it clears both registers' valid flags and the frame flag
// and loads the configuration defaults. A stalled result holds the input side only
// once the input register is also full.
module ascii_response_frame_checker_top #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [0] frame_valid, [32:1] field_value, [33] success,
                                   // [49:34] computed_crc, [55:50] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    arfc_pkg::cfg_t    cfg_reg, cfg_next;
    logic              in_valid_reg, in_valid_next;
    logic [7:0]        in_byte_reg;
    logic              out_valid_reg, out_valid_next;
    arfc_pkg::result_t out_res_reg;

    logic              advance;
    logic              s_xfer;
    logic              res_valid;
    arfc_pkg::result_t res;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign s_xfer    = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {6'b000000, out_res_reg};

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                arfc_pkg::REG_START_CHAR: cfg_next.start_char     = cfg_data[7:0];
                arfc_pkg::REG_END_CHAR:   cfg_next.end_char       = cfg_data[7:0];
                arfc_pkg::REG_SEP_CHAR:   cfg_next.separator_char = cfg_data[7:0];
                arfc_pkg::REG_CRC_PRESET: cfg_next.crc_preset     = cfg_data;
                default:                  cfg_next = cfg_reg;
            endcase
        end
        in_valid_next = s_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        if (advance && res_valid) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    arfc_frame_core #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .rx_byte   (in_byte_reg),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_char     <= arfc_pkg::START_CHAR_RST;
            cfg_reg.end_char       <= arfc_pkg::END_CHAR_RST;
            cfg_reg.separator_char <= arfc_pkg::SEP_CHAR_RST;
            cfg_reg.crc_preset     <= arfc_pkg::CRC_PRESET_RST;
            in_valid_reg           <= 1'b0;
            out_valid_reg          <= 1'b0;
        end else begin
            cfg_reg       <= cfg_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
        if (s_xfer) begin
            in_byte_reg <= s_tdata;
        end
        if (advance && res_valid) begin
            out_res_reg <= res;
        end
    end

endmodule

// ===== design/arfc_frame_core.sv =====
module arfc_frame_core #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic [7:0]        rx_byte,
    input  arfc_pkg::cfg_t    cfg,
    output logic              res_valid,
    output arfc_pkg::result_t res
);

    localparam int PW = VALUE_WIDTH + 4;

    logic                   in_frame_reg, in_frame_next;
    logic [15:0]            crc_run_reg, crc_run_next;
    logic [15:0]            crc_sep_reg, crc_sep_next;
    logic [1:0]             field_cnt_reg, field_cnt_next;
    logic [VALUE_WIDTH-1:0] value_acc_reg, value_acc_next;
    logic                   value_bad_reg, value_bad_next;
    logic                   value_seen_reg, value_seen_next;
    arfc_pkg::token_t       token_reg, token_next;
    logic [16:0]            last_acc_reg, last_acc_next;
    logic                   last_bad_reg, last_bad_next;
    logic                   last_seen_reg, last_seen_next;

    logic                   digit;
    logic [3:0]             dval;
    logic [7:0]             dsub;
    logic [15:0]            crc_new;
    logic [PW-1:0]          acc_ext;
    logic [PW-1:0]          acc_prod;
    logic [20:0]            last_ext;
    logic [20:0]            last_prod;
    logic [15:0]            rx_crc;
    logic                   valid;
    logic [63:0]            value_wide;

    always_comb begin
        dsub      = rx_byte - arfc_pkg::CHAR_ZERO;
        digit     = (rx_byte >= arfc_pkg::CHAR_ZERO) && (rx_byte <= arfc_pkg::CHAR_NINE);
        dval      = dsub[3:0];
        crc_new   = arfc_pkg::crc16_byte(crc_run_reg, rx_byte);
        acc_ext   = PW'(value_acc_reg);
        acc_prod  = (acc_ext << 3) + (acc_ext << 1) + PW'(dval);
        last_ext  = 21'(last_acc_reg);
        last_prod = (last_ext << 3) + (last_ext << 1) + 21'(dval);

        rx_crc = (last_bad_reg || !last_seen_reg || last_acc_reg[16]) ? 16'h0000
                                                                    : last_acc_reg[15:0];
        valid  = (field_cnt_reg >= 2'd2) && (rx_crc == crc_sep_reg);
        value_wide = (valid && value_seen_reg && !value_bad_reg) ? 64'(value_acc_reg)
                                                                  : 64'd0;
        res.frame_valid  = valid;
        res.field_value  = value_wide[31:0];
        res.success      = valid && (token_reg == arfc_pkg::TOK_MATCH);
        res.computed_crc = crc_sep_reg;
    end

    always_comb begin
        in_frame_next   = in_frame_reg;
        crc_run_next    = crc_run_reg;
        crc_sep_next    = crc_sep_reg;
        field_cnt_next  = field_cnt_reg;
        value_acc_next  = value_acc_reg;
        value_bad_next  = value_bad_reg;
        value_seen_next = value_seen_reg;
        token_next      = token_reg;
        last_acc_next   = last_acc_reg;
        last_bad_next   = last_bad_reg;
        last_seen_next  = last_seen_reg;
        res_valid       = 1'b0;

        if (step) begin
            if (!in_frame_reg) begin
                if (rx_byte == cfg.start_char) begin
                    in_frame_next   = 1'b1;
                    crc_run_next    = cfg.crc_preset;
                    crc_sep_next    = cfg.crc_preset;
                    field_cnt_next  = 2'd0;
                    value_acc_next  = '0;
                    value_bad_next  = 1'b0;
                    value_seen_next = 1'b0;
                    token_next      = arfc_pkg::TOK_NONE;
                    last_acc_next   = 17'd0;
                    last_bad_next   = 1'b0;
                    last_seen_next  = 1'b0;
                end
            end else if (rx_byte == cfg.end_char) begin
                res_valid     = 1'b1;
                in_frame_next = 1'b0;
            end else begin
                crc_run_next = crc_new;
                if (rx_byte == cfg.separator_char) begin
                    crc_sep_next   = crc_new;
                    field_cnt_next = (field_cnt_reg == 2'd3) ? 2'd3 : field_cnt_reg + 2'd1;
                    last_acc_next  = 17'd0;
                    last_bad_next  = 1'b0;
                    last_seen_next = 1'b0;
                end else begin
                    if (field_cnt_reg == 2'd1) begin
                        value_seen_next = 1'b1;
                        if (!digit) begin
                            value_bad_next = 1'b1;
                        end else if (!value_bad_reg) begin
                            if (|acc_prod[PW-1:VALUE_WIDTH]) begin
                                value_bad_next = 1'b1;
                            end else begin
                                value_acc_next = acc_prod[VALUE_WIDTH-1:0];
                            end
                        end
                        case (token_reg)
                            arfc_pkg::TOK_NONE: begin
                                token_next = (rx_byte == arfc_pkg::CHAR_DOLLAR)
                                             ? arfc_pkg::TOK_DOLLAR : arfc_pkg::TOK_MISMATCH;
                            end
                            arfc_pkg::TOK_DOLLAR: begin
                                token_next = (rx_byte == arfc_pkg::CHAR_ZERO)
                                             ? arfc_pkg::TOK_MATCH : arfc_pkg::TOK_MISMATCH;
                            end
                            default: begin
                                token_next = arfc_pkg::TOK_MISMATCH;
                            end
                        endcase
                    end
                    last_seen_next = 1'b1;
                    if (!digit) begin
                        last_bad_next = 1'b1;
                    end else if (!last_bad_reg) begin
                        last_acc_next = (last_acc_reg[16] || (last_prod > 21'h10000))
                                        ? 17'h10000 : last_prod[16:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
        end else begin
            in_frame_reg <= in_frame_next;
        end
        crc_run_reg    <= crc_run_next;
        crc_sep_reg    <= crc_sep_next;
        field_cnt_reg  <= field_cnt_next;
        value_acc_reg  <= value_acc_next;
        value_bad_reg  <= value_bad_next;
        value_seen_reg <= value_seen_next;
        token_reg      <= token_next;
        last_acc_reg   <= last_acc_next;
        last_bad_reg   <= last_bad_next;
        last_seen_reg  <= last_seen_next;
    end

endmodule

// ===== design/arfc_checker.sv =====
module arfc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata
);

    // hold a stalled result transfer
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[33] |-> m_tdata[0])
        else $error("success without a valid frame");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[32:1] == 32'd0)
        else $error("field value on a bad frame");

    // a free result side never blocks input
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid && m_tready |-> s_tready)
        else $error("input stalled with an empty result side");

endmodule

bind ascii_response_frame_checker_top arfc_checker u_arfc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
